// File: design/cc_cv_charge_controller_top_defines.svh
// assertion macros for the charge controller
`ifndef CC_CV_CHARGE_CONTROLLER_TOP_DEFINES_SVH
`define CC_CV_CHARGE_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("charge controller: same-cycle check failed");
`define CCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("charge controller: next-cycle check failed");
`else
`define CCC_ASSERT_IMP(label, ante, cons)
`define CCC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/ccc_pkg.sv
package ccc_pkg;

  localparam int unsigned TICKS_PER_MINUTE_DEF = 6000;
  localparam logic [15:0] END_CURRENT_MA       = 16'd500;
  localparam logic [15:0] STANDBY_CURRENT_MA   = 16'd200;
  localparam int unsigned FAST_GAIN            = 2;

  // setpoint width: voltage plus or minus the largest step
  localparam int unsigned SP_W  = 19;
  localparam int unsigned TGT_W = 19;

  localparam int unsigned DAC_GAIN   = 3997;
  localparam int unsigned DAC_OFFSET = 1133838;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_REST   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] CFG_TRICKLE_TARGET  = 3'd0;
  localparam logic [2:0] CFG_TRICKLE_CURRENT = 3'd1;
  localparam logic [2:0] CFG_CC_TARGET       = 3'd2;
  localparam logic [2:0] CFG_CC_CURRENT      = 3'd3;
  localparam logic [2:0] CFG_CV_VOLTAGE      = 3'd4;
  localparam logic [2:0] CFG_TARGET_MINUTES  = 3'd5;
  localparam logic [2:0] CFG_COMPENSATION    = 3'd6;
  localparam logic [2:0] CFG_FAST_CHARGE     = 3'd7;

  typedef enum logic [1:0] {
    MS_STANDBY     = 2'd0,
    MS_CHARGING    = 2'd1,
    MS_DISCHARGING = 2'd2
  } mstate_t;

  typedef enum logic [2:0] {
    STAGE_TRICKLE = 3'd0,
    STAGE_CC      = 3'd1,
    STAGE_CV      = 3'd2,
    STAGE_END     = 3'd3,
    STAGE_NONE    = 3'd4
  } stage_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] voltage_mv;
    logic [15:0] current_ma;
    logic        discharge_enable;
  } in_item_t;

  typedef struct packed {
    mstate_t     machine_state;
    stage_t      charge_stage;
    logic        power_on;
    logic        fan_on;
    logic        dac_write;
    logic [11:0] dac_code;
    logic [15:0] charge_minutes;
    logic [31:0] charge_quantity;
    logic        end_flag;
  } out_item_t;

endpackage

// File: design/cc_cv_charge_controller_top.sv
// CC/CV charge controller. One transaction per clock is accepted on the input
// channel unless in_stall is high; each produces exactly one result, which
// passes the input register, then the result register. Throughput is one item
// per cycle while out_stall does not hold the result register, set by the single
// state update between the input and result registers; the step setpoints are
// prepared as the item enters the input register. Configuration writes are taken
// in any cycle (cfg_ready is held high) and must be made while idle.
`include "cc_cv_charge_controller_top_defines.svh"

module cc_cv_charge_controller_top #(
  parameter int unsigned TICKS_PER_MINUTE = ccc_pkg::TICKS_PER_MINUTE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ccc_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ccc_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int unsigned SUB_W = (TICKS_PER_MINUTE > 1) ? $clog2(TICKS_PER_MINUTE) : 1;
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_MINUTE - 1);
  localparam int unsigned SP_W  = ccc_pkg::SP_W;
  localparam int unsigned TGT_W = ccc_pkg::TGT_W;

  function automatic logic signed [SP_W-1:0] track_sp(
    input logic [15:0]      v,
    input logic [15:0]      i,
    input logic [TGT_W-1:0] tgt,
    input logic [15:0]      comp
  );
    logic signed [TGT_W:0] d;
    logic [TGT_W:0]        a;
    logic [16:0]           s;
    d = $signed({{(TGT_W - 15){1'b0}}, i}) - $signed({1'b0, tgt});
    a = d[TGT_W] ? (TGT_W + 1)'(-d) : (TGT_W + 1)'(d);
    if (a < (TGT_W + 1)'(1000)) begin
      s = 17'd0;
    end else if (a < (TGT_W + 1)'(2000)) begin
      s = 17'd100 + {1'b0, comp};
    end else if (a < (TGT_W + 1)'(3000)) begin
      s = 17'd200 + {1'b0, comp};
    end else if (a < (TGT_W + 1)'(4000)) begin
      s = 17'd400 + {1'b0, comp};
    end else begin
      s = 17'd600 + {1'b0, comp};
    end
    if (d <= 0) begin
      track_sp = $signed({{(SP_W - 16){1'b0}}, v}) + $signed({{(SP_W - 17){1'b0}}, s});
    end else begin
      track_sp = $signed({{(SP_W - 16){1'b0}}, v}) - $signed({{(SP_W - 17){1'b0}}, s});
    end
  endfunction

  function automatic logic [11:0] dac_from_mv(input logic signed [SP_W-1:0] mv);
    logic signed [32:0] prod;
    prod = $signed({{(33 - SP_W){mv[SP_W-1]}}, mv}) * 33'sd3997 + 33'sd1133838;
    if (mv == '0) begin
      dac_from_mv = 12'd0;
    end else if (prod[32]) begin
      dac_from_mv = 12'd0;
    end else if (|prod[31:28]) begin
      dac_from_mv = 12'hFFF;
    end else begin
      dac_from_mv = prod[27:16];
    end
  endfunction

  // configuration registers
  logic [15:0] trickle_target_r, trickle_current_r, cc_target_r, cc_current_r;
  logic [15:0] cv_voltage_r, target_minutes_r, compensation_r;
  logic        fast_charge_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trickle_target_r  <= 16'd40000;
      trickle_current_r <= 16'd1000;
      cc_target_r       <= 16'd48000;
      cc_current_r      <= 16'd2000;
      cv_voltage_r      <= 16'd52000;
      target_minutes_r  <= 16'd120;
      compensation_r    <= 16'd100;
      fast_charge_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccc_pkg::CFG_TRICKLE_TARGET:  trickle_target_r  <= cfg_data;
        ccc_pkg::CFG_TRICKLE_CURRENT: trickle_current_r <= cfg_data;
        ccc_pkg::CFG_CC_TARGET:       cc_target_r       <= cfg_data;
        ccc_pkg::CFG_CC_CURRENT:      cc_current_r      <= cfg_data;
        ccc_pkg::CFG_CV_VOLTAGE:      cv_voltage_r      <= cfg_data;
        ccc_pkg::CFG_TARGET_MINUTES:  target_minutes_r  <= cfg_data;
        ccc_pkg::CFG_COMPENSATION:    compensation_r    <= cfg_data;
        ccc_pkg::CFG_FAST_CHARGE:     fast_charge_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register with precomputed step setpoints
  logic                      s1_valid_r;
  ccc_pkg::in_item_t         s1_data_r;
  logic signed [SP_W-1:0]    s1_sp_trk_r, s1_sp_cc_r;
  logic [TGT_W-1:0]          cc_tgt;
  logic                      advance, fire;

  logic                      out_valid_r;
  ccc_pkg::out_item_t        out_data_r;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  assign cc_tgt = fast_charge_r ? TGT_W'(cc_current_r * ccc_pkg::FAST_GAIN)
                                : {{(TGT_W - 16){1'b0}}, cc_current_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r   <= in_data;
      s1_sp_trk_r <= track_sp(in_data.voltage_mv, in_data.current_ma,
                              {{(TGT_W - 16){1'b0}}, trickle_current_r}, compensation_r);
      s1_sp_cc_r  <= track_sp(in_data.voltage_mv, in_data.current_ma, cc_tgt,
                              compensation_r);
    end
  end

  // controller state
  logic [15:0]       rest_r, rest_nxt;
  logic              pending_r, pending_nxt;
  logic              timing_r, timing_nxt;
  logic              ended_r, ended_nxt;
  logic [SUB_W-1:0]  sub_r, sub_nxt;
  logic [15:0]       minutes_r, minutes_nxt;
  logic [31:0]       qty_r, qty_nxt;
  ccc_pkg::mstate_t  mstate_r, mstate_nxt;
  logic              power_r, power_nxt;
  logic              fan_r, fan_nxt;
  logic [11:0]       dac_r, dac_nxt;

  ccc_pkg::stage_t        stage;
  logic                   wrote;
  logic signed [SP_W-1:0] sp_sel;
  logic [15:0]            rest_eff;
  logic [32:0]            qty_sum;

  always_comb begin
    rest_nxt    = rest_r;
    pending_nxt = pending_r;
    timing_nxt  = timing_r;
    ended_nxt   = ended_r;
    sub_nxt     = sub_r;
    minutes_nxt = minutes_r;
    qty_nxt     = qty_r;
    mstate_nxt  = mstate_r;
    power_nxt   = power_r;
    fan_nxt     = fan_r;
    stage       = ccc_pkg::STAGE_NONE;
    wrote       = 1'b0;
    sp_sel      = '0;
    rest_eff    = pending_r ? s1_data_r.voltage_mv : rest_r;
    qty_sum     = {1'b0, qty_r} + {17'd0, s1_data_r.current_ma};
    case (s1_data_r.op)
      ccc_pkg::OP_SAMPLE: begin
        if (s1_data_r.discharge_enable) begin
          mstate_nxt = ccc_pkg::MS_DISCHARGING;
        end else if (s1_data_r.current_ma < ccc_pkg::STANDBY_CURRENT_MA) begin
          pending_nxt = 1'b1;
          mstate_nxt  = ccc_pkg::MS_STANDBY;
          timing_nxt  = 1'b0;
          ended_nxt   = 1'b0;
          power_nxt   = 1'b0;
          fan_nxt     = 1'b0;
        end else begin
          pending_nxt = 1'b0;
          rest_nxt    = rest_eff;
          mstate_nxt  = ccc_pkg::MS_CHARGING;
          timing_nxt  = 1'b1;
          power_nxt   = 1'b1;
          fan_nxt     = 1'b1;
          wrote       = 1'b1;
          if (rest_eff < trickle_target_r) begin
            stage  = ccc_pkg::STAGE_TRICKLE;
            sp_sel = s1_sp_trk_r;
          end else if (rest_eff < cc_target_r) begin
            stage  = ccc_pkg::STAGE_CC;
            sp_sel = s1_sp_cc_r;
          end else if (s1_data_r.current_ma < ccc_pkg::END_CURRENT_MA ||
                       minutes_r >= target_minutes_r) begin
            stage     = ccc_pkg::STAGE_END;
            ended_nxt = 1'b1;
            power_nxt = 1'b0;
            fan_nxt   = 1'b0;
          end else begin
            stage  = ccc_pkg::STAGE_CV;
            sp_sel = $signed({{(SP_W - 16){1'b0}}, cv_voltage_r});
          end
        end
      end
      ccc_pkg::OP_REST: begin
        rest_nxt  = s1_data_r.voltage_mv;
        power_nxt = 1'b0;
      end
      ccc_pkg::OP_TICK: begin
        if (timing_r && !ended_r) begin
          if (sub_r == SUB_LAST) begin
            sub_nxt = '0;
            if (minutes_r != 16'hFFFF) begin
              minutes_nxt = minutes_r + 16'd1;
            end
          end else begin
            sub_nxt = sub_r + SUB_W'(1);
          end
          qty_nxt = qty_sum[32] ? 32'hFFFF_FFFF : qty_sum[31:0];
        end else begin
          sub_nxt     = '0;
          minutes_nxt = 16'd0;
          qty_nxt     = 32'd0;
        end
      end
      default: ;
    endcase
    dac_nxt = wrote ? dac_from_mv(sp_sel) : dac_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r    <= 16'd0;
      pending_r <= 1'b1;
      timing_r  <= 1'b0;
      ended_r   <= 1'b0;
      sub_r     <= '0;
      minutes_r <= 16'd0;
      qty_r     <= 32'd0;
      mstate_r  <= ccc_pkg::MS_STANDBY;
      power_r   <= 1'b0;
      fan_r     <= 1'b0;
      dac_r     <= 12'd0;
    end else if (fire) begin
      rest_r    <= rest_nxt;
      pending_r <= pending_nxt;
      timing_r  <= timing_nxt;
      ended_r   <= ended_nxt;
      sub_r     <= sub_nxt;
      minutes_r <= minutes_nxt;
      qty_r     <= qty_nxt;
      mstate_r  <= mstate_nxt;
      power_r   <= power_nxt;
      fan_r     <= fan_nxt;
      dac_r     <= dac_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.machine_state   <= mstate_nxt;
      out_data_r.charge_stage    <= stage;
      out_data_r.power_on        <= power_nxt;
      out_data_r.fan_on          <= fan_nxt;
      out_data_r.dac_write       <= wrote;
      out_data_r.dac_code        <= dac_nxt;
      out_data_r.charge_minutes  <= minutes_nxt;
      out_data_r.charge_quantity <= qty_nxt;
      out_data_r.end_flag        <= ended_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CCC_ASSERT_IMP(a_sub_range, 1'b1, sub_r <= SUB_LAST)
  `CCC_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_r)
  `CCC_ASSERT_IMP(a_write_when_charging, out_valid_r && out_data_r.dac_write,
                  out_data_r.machine_state == ccc_pkg::MS_CHARGING &&
                  out_data_r.charge_stage != ccc_pkg::STAGE_NONE)
  `CCC_ASSERT_IMP(a_end_stage_off,
                  out_valid_r && out_data_r.charge_stage == ccc_pkg::STAGE_END,
                  out_data_r.end_flag && out_data_r.dac_code == 12'd0 &&
                  !out_data_r.power_on)

endmodule
